// ----- design/ddt_pkg.sv -----
// ----------------------------------------------------------------------------
// ddt_pkg: shared definitions for the delimiter depth tracker
// Character codes, configuration register indexes, field widths and the
// result and configuration write structures passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddt_pkg;

  // Field widths fixed by the interface.
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int TOTAL_W    = 11;
  localparam int HASH_W     = 32;
  localparam int MAXD_W     = 11;
  localparam int NUMN_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Default saturation point of each bracket counter.
  localparam int DEPTH_LIMIT_DEF = 255;

  // Largest value the total depth field can show.
  localparam int TOTAL_MAX = 2047;

  // Reset values of the configuration registers.
  localparam logic [MAXD_W-1:0] MAXD_RST = 11'd255;
  localparam logic [NUMN_W-1:0] NUMN_RST = 8'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NESTING  = 1'd1;

  // Input action codes.
  localparam logic ACT_COMMIT      = 1'b0;
  localparam logic ACT_SPECULATIVE = 1'b1;

  // Bracket kinds, in counter order: curly, square, angle, round.
  localparam int NUM_KINDS = 4;
  localparam logic [NUM_KINDS-1:0][CHAR_W-1:0] OPEN_CHARS =
    {8'h28, 8'h3C, 8'h5B, 8'h7B};   // ( < [ {  (index 3 down to 0)
  localparam logic [NUM_KINDS-1:0][CHAR_W-1:0] CLOSE_CHARS =
    {8'h29, 8'h3E, 8'h5D, 8'h7D};   // ) > ] }
  localparam logic [CHAR_W-1:0] QUOTE_CHAR = 8'h22;

  localparam logic [HASH_W-1:0] HASH_RST = 32'd0;

  typedef struct packed {
    logic [COUNT_W-1:0] curly_count;
    logic [COUNT_W-1:0] square_count;
    logic [COUNT_W-1:0] angle_count;
    logic [COUNT_W-1:0] round_count;
    logic               in_quote;
    logic [TOTAL_W-1:0] total_depth;
    logic [HASH_W-1:0]  hash_a;
    logic [HASH_W-1:0]  hash_b;
    logic               within_limit;
  } ddt_result_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } ddt_cfg_wr_t;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } ddt_item_t;

endpackage

`default_nettype wire

// ----- design/ddt_ctx.sv -----
// ----------------------------------------------------------------------------
// ddt_ctx: nesting context and per-character update
// Holds the committed depths, quote bit, rolling hashes, the speculative
// shadow copy and the configuration registers; works out one result a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ddt_ctx #(
  parameter int DEPTH_LIMIT = ddt_pkg::DEPTH_LIMIT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ddt_pkg::ddt_cfg_wr_t cfg_wr,
  input  wire                  step_en,
  input  ddt_pkg::ddt_item_t   item,
  output ddt_pkg::ddt_result_t res
);
  import ddt_pkg::*;

  localparam int CW    = $clog2(DEPTH_LIMIT + 1);
  localparam int SUMB  = (CW > NUMN_W) ? CW : NUMN_W;
  localparam int TOT_W = SUMB + 3;

  typedef logic [NUM_KINDS-1:0][CW-1:0] cnt_set_t;

  cnt_set_t            cnt_r, cnt_nxt;
  logic                quote_r, quote_nxt;
  cnt_set_t            sh_cnt_r, sh_cnt_nxt;
  logic                sh_quote_r, sh_quote_nxt;
  logic                sh_act_r, sh_act_nxt;
  logic [HASH_W-1:0]   hash_a_r, hash_a_nxt;
  logic [HASH_W-1:0]   hash_b_r, hash_b_nxt;
  logic [MAXD_W-1:0]   maxd_r;
  logic [NUMN_W-1:0]   numn_r;

  cnt_set_t            base_cnt, new_cnt;
  logic                base_quote, new_quote;
  logic                is_delim;
  logic [TOT_W-1:0]    total;
  logic [HASH_W-1:0]   c_ext;

  // Speculation starts from the committed depths unless a shadow is live.
  always_comb begin
    if (item.action == ACT_SPECULATIVE && sh_act_r) begin
      base_cnt   = sh_cnt_r;
      base_quote = sh_quote_r;
    end else begin
      base_cnt   = cnt_r;
      base_quote = quote_r;
    end
  end

  // Depth rule: opening characters count up to the limit, closing ones
  // count down to zero, a double quote toggles the quote bit.
  always_comb begin
    new_cnt   = base_cnt;
    new_quote = base_quote;
    is_delim  = 1'b0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (item.char_code == OPEN_CHARS[k]) begin
        is_delim = 1'b1;
        if (base_cnt[k] < CW'(DEPTH_LIMIT)) begin
          new_cnt[k] = base_cnt[k] + CW'(1);
        end
      end
      if (item.char_code == CLOSE_CHARS[k]) begin
        is_delim = 1'b1;
        if (base_cnt[k] != '0) begin
          new_cnt[k] = base_cnt[k] - CW'(1);
        end
      end
    end
    if (item.char_code == QUOTE_CHAR) begin
      is_delim  = 1'b1;
      new_quote = ~base_quote;
    end
  end

  assign total = TOT_W'(new_cnt[0]) + TOT_W'(new_cnt[1]) + TOT_W'(new_cnt[2])
               + TOT_W'(new_cnt[3]) + TOT_W'(new_quote) + TOT_W'(numn_r);

  assign c_ext = HASH_W'(item.char_code);

  always_comb begin
    cnt_nxt      = cnt_r;
    quote_nxt    = quote_r;
    sh_cnt_nxt   = sh_cnt_r;
    sh_quote_nxt = sh_quote_r;
    sh_act_nxt   = sh_act_r;
    hash_a_nxt   = hash_a_r;
    hash_b_nxt   = hash_b_r;
    if (step_en) begin
      if (item.action == ACT_SPECULATIVE) begin
        sh_cnt_nxt   = new_cnt;
        sh_quote_nxt = new_quote;
        sh_act_nxt   = ~item.last;
      end else begin
        cnt_nxt    = new_cnt;
        quote_nxt  = new_quote;
        sh_act_nxt = 1'b0;
        if (!is_delim) begin
          // x31 = x*32 - x, x37 = x*32 + x*4 + x
          hash_a_nxt = (hash_a_r << 5) - hash_a_r + c_ext;
          hash_b_nxt = (hash_b_r << 5) + (hash_b_r << 2) + hash_b_r + c_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      quote_r    <= 1'b0;
      sh_cnt_r   <= '0;
      sh_quote_r <= 1'b0;
      sh_act_r   <= 1'b0;
      hash_a_r   <= HASH_RST;
      hash_b_r   <= HASH_RST;
      maxd_r     <= MAXD_RST;
      numn_r     <= NUMN_RST;
    end else begin
      cnt_r      <= cnt_nxt;
      quote_r    <= quote_nxt;
      sh_cnt_r   <= sh_cnt_nxt;
      sh_quote_r <= sh_quote_nxt;
      sh_act_r   <= sh_act_nxt;
      hash_a_r   <= hash_a_nxt;
      hash_b_r   <= hash_b_nxt;
      if (cfg_wr.wr) begin
        unique case (cfg_wr.idx)
          REG_MAX_TOTAL_DEPTH: maxd_r <= cfg_wr.data[MAXD_W-1:0];
          REG_NUMBER_NESTING:  numn_r <= cfg_wr.data[NUMN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Counts, quote, hashes: committed state; total, within_limit: new_cnt.
  always_comb begin
    res.curly_count  = COUNT_W'(cnt_nxt[0]);
    res.square_count = COUNT_W'(cnt_nxt[1]);
    res.angle_count  = COUNT_W'(cnt_nxt[2]);
    res.round_count  = COUNT_W'(cnt_nxt[3]);
    res.in_quote     = quote_nxt;
    res.hash_a       = hash_a_nxt;
    res.hash_b       = hash_b_nxt;
    res.total_depth  = (total > TOT_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                   : total[TOTAL_W-1:0];
    res.within_limit = (total <= TOT_W'(maxd_r));
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(DEPTH_LIMIT) && cnt_r[1] <= CW'(DEPTH_LIMIT) &&
    cnt_r[2] <= CW'(DEPTH_LIMIT) && cnt_r[3] <= CW'(DEPTH_LIMIT))
    else $error("committed counter above its limit");

  a_commit_ends_spec: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.action == ACT_COMMIT |=> !sh_act_r)
    else $error("shadow still live after a commit");

  a_spec_keeps_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.action == ACT_SPECULATIVE |=>
      $stable(cnt_r) && $stable(quote_r) && $stable(hash_a_r) && $stable(hash_b_r))
    else $error("speculative character altered committed context");

endmodule

`default_nettype wire

// ----- design/delimiter_depth_tracker_top.sv -----
// ----------------------------------------------------------------------------
// delimiter_depth_tracker_top: bracket nesting depth tracker
// Tracks four bracket depths, a quote bit and two rolling hashes over a
// character stream, with speculative checks on a shadow copy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one signature character a beat, with its action
//   (commit or speculative check) and an end-of-signature flag. A beat is
//   taken when in_valid is high and in_stall is low.
//   Result channel (out_*): exactly one result beat per input beat, in
//   order, taken when out_valid is high and out_stall is low.
//   Configuration (cfg_*): cfg_ready is always high; index 0 writes the
//   greatest valid total depth, index 1 the fixed number depth. Writes are
//   expected only while no character is in flight.
//   Path: a character is held in the input register, its context update is
//   worked out from there and the result is kept in the result register.
//   Throughput: one character per cycle while out_stall is low. The whole
//   context update is one pass of shallow logic between the input register
//   and the result register, so consecutive characters follow without a gap.
//   Stalls: while out_stall holds a waiting result, the character in the
//   input register is kept and in_stall rises; nothing is dropped.
//   Reset (rst_n low, synchronous): all depths, the quote bit, hashes and
//   the shadow copy clear; the limit returns to 255 and the number depth to
//   0; both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_depth_tracker_top #(
  parameter int DEPTH_LIMIT = ddt_pkg::DEPTH_LIMIT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration write
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ddt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [ddt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input characters
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_action,
  input  wire  [ddt_pkg::CHAR_W-1:0]       in_char_code,
  input  wire                              in_last_of_signature,
  // results
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [ddt_pkg::COUNT_W-1:0]      out_curly_count,
  output logic [ddt_pkg::COUNT_W-1:0]      out_square_count,
  output logic [ddt_pkg::COUNT_W-1:0]      out_angle_count,
  output logic [ddt_pkg::COUNT_W-1:0]      out_round_count,
  output logic                             out_in_quote,
  output logic [ddt_pkg::TOTAL_W-1:0]      out_total_depth,
  output logic [ddt_pkg::HASH_W-1:0]       out_hash_a,
  output logic [ddt_pkg::HASH_W-1:0]       out_hash_b,
  output logic                             out_within_limit
);
  import ddt_pkg::*;

  ddt_item_t   item_r, item_nxt;
  logic        item_vld_r, item_vld_nxt;
  ddt_result_t res, res_r, res_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        advance;
  ddt_cfg_wr_t cfg_wr;

  assign cfg_ready  = 1'b1;
  assign cfg_wr.wr   = cfg_valid;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_wdata;

  // The held character moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance  = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;

  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (!in_stall) begin
      item_vld_nxt       = in_valid;
      item_nxt.action    = in_action;
      item_nxt.char_code = in_char_code;
      item_nxt.last      = in_last_of_signature;
    end
  end

  always_comb begin
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (advance) begin
      res_nxt     = res;
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  ddt_ctx #(
    .DEPTH_LIMIT (DEPTH_LIMIT)
  ) u_ctx (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .step_en (advance),
    .item    (item_r),
    .res     (res)
  );

  assign out_valid        = out_vld_r;
  assign out_curly_count  = res_r.curly_count;
  assign out_square_count = res_r.square_count;
  assign out_angle_count  = res_r.angle_count;
  assign out_round_count  = res_r.round_count;
  assign out_in_quote     = res_r.in_quote;
  assign out_total_depth  = res_r.total_depth;
  assign out_hash_a       = res_r.hash_a;
  assign out_hash_b       = res_r.hash_b;
  assign out_within_limit = res_r.within_limit;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_vld_r && out_vld_r)
    else $error("input stalled with no character held");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("advanced character produced no result");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    !item_vld_r && out_vld_r && !out_stall |=> !out_vld_r)
    else $error("result repeated after being taken");

endmodule

`default_nettype wire
